// ===== design/hors_pkg.sv =====
// Shared types, constants and helper functions of the RK4 oscillator step block.
package hors_pkg;

	// Default number of fraction bits of all fixed-point quantities.
	localparam int FRAC_BITS_DEF = 16;

	// Configuration port layout.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IPOS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IVEL  = 2'd3;

	// Field and datapath widths.
	localparam int STEP_W  = 16;
	localparam int RATIO_W = 24;
	localparam int VAL_W   = 32;
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int WIDE_W  = 62;
	// Bits that hold the rounded weighted-sum product of the final update.
	localparam int FIN_N_W = 52;
	// Quotient bits that the divide-by-three unit retires in one cycle.
	localparam int DIV_BITS = 8;

	// Sequencer op index width.
	localparam int OP_IDX_W = 4;

	// Operations that the shared multiplier performs.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACC,
		OP_ADVX,
		OP_ADVV,
		OP_FINX,
		OP_FINV
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] stage;
	} op_entry_t;

	// Sequencer program: four RK4 stages, then the two weighted-sum updates.
	function automatic op_entry_t op_at(input logic [OP_IDX_W-1:0] idx);
		op_entry_t e;
		e.op    = OP_NOP;
		e.stage = 2'd0;
		unique case (idx)
			4'd0: begin e.op = OP_ACC;  e.stage = 2'd0; end
			4'd1: begin e.op = OP_ADVX; e.stage = 2'd0; end
			4'd2: begin e.op = OP_ADVV; e.stage = 2'd0; end
			4'd3: begin e.op = OP_ACC;  e.stage = 2'd1; end
			4'd4: begin e.op = OP_ADVX; e.stage = 2'd1; end
			4'd5: begin e.op = OP_ADVV; e.stage = 2'd1; end
			4'd6: begin e.op = OP_ACC;  e.stage = 2'd2; end
			4'd7: begin e.op = OP_ADVX; e.stage = 2'd2; end
			4'd8: begin e.op = OP_ADVV; e.stage = 2'd2; end
			4'd9: begin e.op = OP_ACC;  e.stage = 2'd3; end
			4'd11: begin e.op = OP_FINX; e.stage = 2'd0; end
			4'd13: begin e.op = OP_FINV; e.stage = 2'd0; end
			default: begin e.op = OP_NOP; e.stage = 2'd0; end
		endcase
		return e;
	endfunction

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] a);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = 62'sd2147483647;
		lo = -62'sd2147483648;
		if (a > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (a < lo) begin
			return 32'sh8000_0000;
		end
		return a[VAL_W-1:0];
	endfunction

	// Reset value of the step size: 0.01 rounded, clamped to the register.
	function automatic logic [STEP_W-1:0] step_reset(input int fb);
		int v;
		v = ((1 << fb) + 50) / 100;
		if (v > 65535) begin
			return 16'hFFFF;
		end
		return 16'(v);
	endfunction

	// Reset value of the stiffness ratio: 150.0, clamped to the register.
	function automatic logic [RATIO_W-1:0] ratio_reset(input int fb);
		longint v;
		v = longint'(150) << fb;
		if (v > 64'sd16777215) begin
			return 24'hFF_FFFF;
		end
		return 24'(v);
	endfunction

	// Reset value of the initial position: 0.1 rounded.
	function automatic logic signed [VAL_W-1:0] pos_reset(input int fb);
		int v;
		v = ((1 << fb) + 5) / 10;
		return 32'(v);
	endfunction

endpackage

// ===== design/harmonic_oscillator_rk4_step.sv =====
// Top level of the RK4 step block for a mass-spring oscillator.
//
// Every input beat on the in channel (in_valid, in_stall, restart) yields one
// output beat on the out channel (out_valid, out_stall, sim_time, position,
// velocity). With restart low the block advances the stored state by one
// classical fourth-order Runge-Kutta step; with restart high it reloads the
// initial position and velocity registers and clears time.
// A step runs from one accepted beat to the next: the sequencer feeds
// twelve products through the one shared 35x25 multiplier, with two passes of
// the divide-by-three unit at eight quotient bits a cycle, then the write-back
// state and the idle state. The result appears on out_valid in the same cycle
// as the block can take the next beat. A restart beat goes from idle straight
// to the write-back state.
// in_stall is high whenever a beat is in progress.
// The output register holds a finished beat while out_stall is high; the
// next beat is accepted and computed meanwhile and waits at the end until
// the output register frees up.
// Reset loads the register defaults (h = 0.01, ratio = 150, x0 = 0.1,
// v0 = 0), clears time and sets position and velocity to those defaults.
// Configuration writes are registered on cfg_write.
module harmonic_oscillator_rk4_step
	import hors_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [VAL_W-1:0]             sim_time,
	output logic signed [VAL_W-1:0]      position,
	output logic signed [VAL_W-1:0]      velocity
);

	// Divider sizing follows from the fraction width.
	localparam int MW      = FIN_N_W - (FRAC_BITS + 1);
	localparam int UW      = MW + 1;
	localparam int DIV_CYC = (UW + DIV_BITS - 1) / DIV_BITS;
	localparam int DW      = DIV_CYC * DIV_BITS;
	localparam int DCW     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

	localparam logic signed [WIDE_W-1:0] HALF_LO  = 62'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [WIDE_W-1:0] HALF_HI  = 62'sd1 <<< FRAC_BITS;
	localparam logic signed [WIDE_W-1:0] FIN_BIAS = 62'sd3 <<< FRAC_BITS;
	localparam logic signed [WIDE_W-1:0] Q_OFFSET = 62'sd1 <<< (MW - 1);
	localparam logic [UW-1:0]            U_OFFSET = UW'(3) << (MW - 1);

	localparam logic [STEP_W-1:0]       STEP_RST  = step_reset(FRAC_BITS);
	localparam logic [RATIO_W-1:0]      RATIO_RST = ratio_reset(FRAC_BITS);
	localparam logic signed [VAL_W-1:0] IPOS_RST  = pos_reset(FRAC_BITS);
	localparam logic signed [VAL_W-1:0] IVEL_RST  = '0;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CALC = 4'b0010,
		S_DIV  = 4'b0100,
		S_WB   = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [OP_IDX_W-1:0]         op_idx_q;
	op_t                         post_op_q;
	logic [1:0]                  post_stage_q;
	logic [DCW-1:0]              div_cnt_q;
	logic                        div_vel_q;

	logic [STEP_W-1:0]           step_q;
	logic [RATIO_W-1:0]          ratio_q;
	logic signed [VAL_W-1:0]     ipos_q;
	logic signed [VAL_W-1:0]     ivel_q;

	logic [VAL_W-1:0]            time_q;
	logic signed [VAL_W-1:0]     pos_q;
	logic signed [VAL_W-1:0]     vel_q;

	logic signed [MUL_P_W-1:0]   prod_q;
	logic signed [VAL_W-1:0]     x_cur_q;
	logic signed [VAL_W-1:0]     v_cur_q;
	logic signed [VAL_W-1:0]     kv_q;
	logic signed [MUL_A_W-1:0]   sum_x_q;
	logic signed [MUL_A_W-1:0]   sum_v_q;
	logic [DW-1:0]               div_q;
	logic [1:0]                  rem_q;

	logic                        out_valid_q;
	logic [VAL_W-1:0]            sim_time_q;
	logic signed [VAL_W-1:0]     position_q;
	logic signed [VAL_W-1:0]     velocity_q;

	logic                        in_accept;
	logic                        out_free;
	logic                        wb_load;
	logic                        div_last;
	op_entry_t                   issue;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]   mul_b;
	logic signed [MUL_P_W-1:0]   mul_p;

	logic signed [WIDE_W-1:0]    p_ext;
	logic signed [WIDE_W-1:0]    acc_round;
	logic signed [VAL_W-1:0]     acc_sat;
	logic signed [VAL_W-1:0]     kv_new;
	logic                        dbl;
	logic signed [MUL_A_W-1:0]   kv_term;
	logic signed [MUL_A_W-1:0]   v_term;
	logic signed [WIDE_W-1:0]    adv_round;
	logic signed [VAL_W-1:0]     x_adv;
	logic signed [VAL_W-1:0]     v_adv;
	logic signed [WIDE_W-1:0]    fin_n;
	logic signed [WIDE_W-1:0]    fin_m;
	logic [UW-1:0]               fin_u;

	logic [DW-1:0]               div_w;
	logic [1:0]                  div_rm;
	logic [2:0]                  div_tri;
	logic [UW-1:0]               div_quot;
	logic signed [VAL_W-1:0]     div_base;
	logic signed [VAL_W-1:0]     div_res;
	logic [VAL_W:0]              time_sum;
	logic [VAL_W-1:0]            time_next;

	// Handshake terms.
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign wb_load   = (state_q == S_WB) && out_free;
	assign div_last  = (div_cnt_q == DCW'(DIV_CYC - 1));

	// Operand selection for the shared multiplier.
	assign issue = op_at(op_idx_q);

	always_comb begin
		mul_a = '0;
		mul_b = MUL_B_W'(step_q);
		case (issue.op)
			OP_ACC: begin
				mul_a = MUL_A_W'(x_cur_q);
				mul_b = MUL_B_W'(ratio_q);
			end
			OP_ADVX: mul_a = MUL_A_W'(v_cur_q);
			OP_ADVV: mul_a = MUL_A_W'(kv_q);
			OP_FINX: mul_a = sum_x_q;
			OP_FINV: mul_a = sum_v_q;
			default: mul_a = '0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Post-processing of the registered product.
	assign p_ext     = WIDE_W'(prod_q);
	assign acc_round = (p_ext + HALF_LO) >>> FRAC_BITS;
	assign acc_sat   = sat32(acc_round);
	assign kv_new    = sat32(-(WIDE_W'(acc_sat)));
	// The two midpoint stages carry weight two in the final sums.
	assign dbl       = (post_stage_q == 2'd1) || (post_stage_q == 2'd2);
	assign kv_term   = dbl ? (MUL_A_W'(kv_new) <<< 1) : MUL_A_W'(kv_new);
	assign v_term    = dbl ? (MUL_A_W'(v_cur_q) <<< 1) : MUL_A_W'(v_cur_q);

	// Half steps for the first two stages, a full step for the last one.
	assign adv_round = (post_stage_q == 2'd2) ? ((p_ext + HALF_LO) >>> FRAC_BITS)
	                                          : ((p_ext + HALF_HI) >>> (FRAC_BITS + 1));
	assign x_adv     = sat32(WIDE_W'(pos_q) + adv_round);
	assign v_adv     = sat32(WIDE_W'(vel_q) + adv_round);

	// Rounded h*S scaled down by 2^(F+1), then biased positive by a multiple of three.
	assign fin_n = p_ext + FIN_BIAS;
	assign fin_m = fin_n >>> (FRAC_BITS + 1);
	assign fin_u = UW'(fin_m) + U_OFFSET;

	// Restoring divide by three, MSB first, eight quotient bits per cycle.
	always_comb begin
		div_w   = div_q;
		div_rm  = rem_q;
		div_tri = '0;
		for (int j = 0; j < DIV_BITS; j++) begin
			div_tri = {div_rm, div_w[DW-1]};
			div_w   = {div_w[DW-2:0], (div_tri >= 3'd3)};
			div_rm  = (div_tri >= 3'd3) ? 2'(div_tri - 3'd3) : div_tri[1:0];
		end
	end

	assign div_quot = div_w[UW-1:0];
	assign div_base = div_vel_q ? vel_q : pos_q;
	assign div_res  = sat32(WIDE_W'(div_base) + $signed(WIDE_W'(div_quot)) - Q_OFFSET);

	// Elapsed time saturates at its maximum.
	assign time_sum  = {1'b0, time_q} + (VAL_W + 1)'(step_q);
	assign time_next = time_sum[VAL_W] ? '1 : time_sum[VAL_W-1:0];

	// Control state, configuration and the integrator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_idx_q     <= '0;
			post_op_q    <= OP_NOP;
			post_stage_q <= '0;
			div_cnt_q    <= '0;
			div_vel_q    <= 1'b0;
			step_q       <= STEP_RST;
			ratio_q      <= RATIO_RST;
			ipos_q       <= IPOS_RST;
			ivel_q       <= IVEL_RST;
			time_q       <= '0;
			pos_q        <= IPOS_RST;
			vel_q        <= IVEL_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_STEP:  step_q  <= cfg_data[STEP_W-1:0];
					REG_RATIO: ratio_q <= cfg_data[RATIO_W-1:0];
					REG_IPOS:  ipos_q  <= $signed(cfg_data);
					REG_IVEL:  ivel_q  <= $signed(cfg_data);
				endcase
			end

			post_op_q    <= (state_q == S_CALC) ? issue.op : OP_NOP;
			post_stage_q <= issue.stage;

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (restart) begin
							time_q  <= '0;
							pos_q   <= ipos_q;
							vel_q   <= ivel_q;
							state_q <= S_WB;
						end else begin
							op_idx_q <= '0;
							state_q  <= S_CALC;
						end
					end
				end
				S_CALC: begin
					op_idx_q <= op_idx_q + OP_IDX_W'(1);
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_last) begin
						if (div_vel_q) begin
							vel_q   <= div_res;
							time_q  <= time_next;
							state_q <= S_WB;
						end else begin
							pos_q   <= div_res;
							state_q <= S_CALC;
						end
					end
				end
				S_WB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// A finished weighted-sum product hands over to the divider.
			if (post_op_q == OP_FINX || post_op_q == OP_FINV) begin
				div_cnt_q <= '0;
				div_vel_q <= (post_op_q == OP_FINV);
				state_q   <= S_DIV;
			end

			// Output register valid flag.
			if (wb_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;

		if (state_q == S_IDLE && in_accept) begin
			x_cur_q <= pos_q;
			v_cur_q <= vel_q;
			sum_x_q <= '0;
			sum_v_q <= '0;
		end

		if (state_q == S_DIV) begin
			div_q <= div_w;
			rem_q <= div_rm;
		end

		case (post_op_q) inside
			OP_ACC: begin
				kv_q    <= kv_new;
				sum_v_q <= sum_v_q + kv_term;
				sum_x_q <= sum_x_q + v_term;
			end
			OP_ADVX: x_cur_q <= x_adv;
			OP_ADVV: v_cur_q <= v_adv;
			OP_FINX, OP_FINV: begin
				div_q <= DW'(fin_u);
				rem_q <= '0;
			end
			default: ;
		endcase

		if (wb_load) begin
			sim_time_q <= time_q;
			position_q <= pos_q;
			velocity_q <= vel_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sim_time  = sim_time_q;
	assign position  = position_q;
	assign velocity  = velocity_q;

endmodule

// ===== design/hors_checker.sv =====
// Port-level checker for the RK4 oscillator step block, with its bind.
module hors_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        restart,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] sim_time,
	input logic [31:0] position,
	input logic [31:0] velocity
);

	// A stalled output beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// A stalled output beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(sim_time) && $stable(position) && $stable(velocity))
		else $error("output payload changed while stalled");

	// A step beat keeps the input side busy while it is computed.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !restart |=> in_stall)
		else $error("input taken again during a step");

	// A restart beat into a free output passes through the write-back state and shows up at time zero.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && restart && !out_valid |-> ##2 (out_valid && sim_time == 32'd0))
		else $error("restart result missing or time not cleared");

endmodule

bind harmonic_oscillator_rk4_step hors_checker u_hors_checker (.*);
